[src/priority_task_scheduler_macros.svh]
`ifndef PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication
`define PTS_ASSERT_SAME(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pts_pkg.sv]
`default_nettype none

package pts_pkg;

    localparam int REQ_W     = 3;
    localparam int PRI_W     = 8;
    localparam int ID_W      = 4;
    localparam int WORD_W    = 32;
    localparam int STEP_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SLOT = 1'b1;

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd1;
    localparam logic [ID_W-1:0]   IDLE_SLOT_RESET = 4'd0;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_SLEEP  = 3'd2,
        REQ_TICK   = 3'd3,
        REQ_SWITCH = 3'd4,
        REQ_START  = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic walk;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_walk;
        logic walk_done;
    } dp_status_t;

endpackage

`default_nettype wire

[src/pts_controller.sv]
`default_nettype none

`include "priority_task_scheduler_macros.svh"

module pts_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire pts_pkg::dp_status_t stat,
    output pts_pkg::ctrl_cmd_t      cmd,
    output logic                    busy
);

    pts_pkg::state_t state_reg;
    pts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pts_pkg::ST_EXEC;
                end
            end
            pts_pkg::ST_EXEC:
            begin
                state_next = stat.is_walk ? pts_pkg::ST_WALK : pts_pkg::ST_IDLE;
            end
            pts_pkg::ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = pts_pkg::ST_FINISH;
                end
            end
            pts_pkg::ST_FINISH:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            pts_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            pts_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            pts_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    `PTS_ASSERT_NEXT(a_accept_exec, clk, rst_n, start && (state_reg == pts_pkg::ST_IDLE), state_reg == pts_pkg::ST_EXEC, "accepted request did not enter execute")
    `PTS_ASSERT_SAME(a_walk_op, clk, rst_n, state_reg == pts_pkg::ST_WALK, stat.is_walk, "slot walk for a request that needs none")
    `PTS_ASSERT_SAME(a_busy_state, clk, rst_n, 1'b1, busy == (state_reg != pts_pkg::ST_IDLE), "busy out of step with the controller state")

endmodule

`default_nettype wire

[src/pts_datapath.sv]
`default_nettype none

`include "priority_task_scheduler_macros.svh"

module pts_datapath #(
    parameter int TASKS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [pts_pkg::REQ_W-1:0]         req_type,
    input  wire logic [pts_pkg::PRI_W-1:0]         priority_req,
    input  wire logic [pts_pkg::ID_W-1:0]          target_task,
    input  wire logic [pts_pkg::WORD_W-1:0]        sleep_ticks,
    input  wire logic [pts_pkg::WORD_W-1:0]        stack_top_in,
    input  wire logic                              cfg_we,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [pts_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire pts_pkg::ctrl_cmd_t                cmd,
    output pts_pkg::dp_status_t                    stat,
    output logic                                   done,
    output logic                                   status,
    output logic [pts_pkg::ID_W-1:0]               task_id,
    output logic [pts_pkg::WORD_W-1:0]             stack_top_out,
    output logic                                   running
);

    localparam int SW         = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int TW         = $clog2(TASKS + 1);
    localparam int MW         = (TW > pts_pkg::ID_W) ? TW : pts_pkg::ID_W;
    localparam int WRAP_STEPS = (1 << pts_pkg::ID_W) / TASKS;

    // slot arithmetic helpers
    function automatic logic [SW-1:0] idle_wrap(input logic [pts_pkg::ID_W-1:0] v);
        logic [MW-1:0] acc;
        acc = MW'(v);
        for (int k = 0; k < WRAP_STEPS; k++)
        begin
            if (acc >= MW'(TASKS))
            begin
                acc = acc - MW'(TASKS);
            end
        end
        return acc[SW-1:0];
    endfunction

    function automatic logic [pts_pkg::ID_W-1:0] to_id(input logic [SW-1:0] s);
        logic [pts_pkg::ID_W+SW-1:0] w;
        w = {{pts_pkg::ID_W{1'b0}}, s};
        return w[pts_pkg::ID_W-1:0];
    endfunction

    function automatic logic [SW-1:0] to_slot(input logic [pts_pkg::ID_W-1:0] t);
        logic [pts_pkg::ID_W+SW-1:0] w;
        w = {{SW{1'b0}}, t};
        return w[SW-1:0];
    endfunction

    // captured request
    logic [pts_pkg::REQ_W-1:0]  req_reg;
    logic [pts_pkg::PRI_W-1:0]  pri_reg;
    logic [pts_pkg::ID_W-1:0]   target_reg;
    logic [pts_pkg::WORD_W-1:0] ticks_reg;
    logic [pts_pkg::WORD_W-1:0] stack_in_reg;

    logic [pts_pkg::STEP_W-1:0] tick_step_reg;
    logic [pts_pkg::ID_W-1:0]   idle_slot_reg;

    logic [TASKS-1:0] alive_reg, alive_next;
    logic [TASKS-1:0] delayed_reg, delayed_next;
    logic [TW-1:0]    total_reg, total_next;
    logic [SW-1:0]    cur_reg, cur_next;
    logic             started_reg, started_next;

    logic [TW-1:0]           cnt_reg, cnt_next;
    logic [SW-1:0]           slot_reg, slot_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [SW-1:0]           pend_slot_reg, pend_slot_next;
    logic [SW-1:0]           best_reg, best_next;
    logic [pts_pkg::PRI_W-1:0] best_pri_reg, best_pri_next;

    logic                       done_reg, done_next;
    logic                       status_reg, status_next;
    logic [pts_pkg::ID_W-1:0]   id_reg, id_next;
    logic [pts_pkg::WORD_W-1:0] stack_out_reg, stack_out_next;

    logic [pts_pkg::PRI_W-1:0]  pri_mem   [TASKS];
    logic [pts_pkg::WORD_W-1:0] sleep_mem [TASKS];
    logic [pts_pkg::WORD_W-1:0] stack_mem [TASKS];

    logic [pts_pkg::PRI_W-1:0]  pri_rd_reg;
    logic [pts_pkg::WORD_W-1:0] sleep_rd_reg;
    logic [pts_pkg::WORD_W-1:0] stack_rd_reg;

    pts_pkg::req_t op;
    logic          is_walk;
    logic          full;
    logic          create_ok;
    logic [SW-1:0] total_slot;
    logic [TW-1:0] slot_inc;
    logic [SW-1:0] nslot;
    logic          issue;
    logic          wakes;

    logic                       pri_we;
    logic                       stack_we;
    logic [SW-1:0]              stack_waddr;
    logic                       sleep_we;
    logic [SW-1:0]              sleep_waddr;
    logic [pts_pkg::WORD_W-1:0] sleep_wdata;

    assign op         = pts_pkg::req_t'(req_reg);
    assign is_walk    = (op == pts_pkg::REQ_TICK) || (op == pts_pkg::REQ_SWITCH)
                        || (op == pts_pkg::REQ_START);
    assign full       = total_reg >= TW'(TASKS);
    assign create_ok  = cmd.exec && (op == pts_pkg::REQ_CREATE) && !full;
    assign total_slot = total_reg[SW-1:0];
    assign slot_inc   = TW'(slot_reg) + TW'(1);
    assign nslot      = (slot_inc >= total_reg) ? '0 : slot_inc[SW-1:0];
    assign issue      = cnt_reg < total_reg;
    assign wakes      = sleep_rd_reg <= pts_pkg::WORD_W'(tick_step_reg);

    assign stat = '{is_walk: is_walk, walk_done: !issue && !pend_valid_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= req_type;
            pri_reg      <= priority_req;
            target_reg   <= target_task;
            ticks_reg    <= sleep_ticks;
            stack_in_reg <= stack_top_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_step_reg <= pts_pkg::TICK_STEP_RESET;
            idle_slot_reg <= pts_pkg::IDLE_SLOT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                pts_pkg::CFG_TICK_STEP: tick_step_reg <= cfg_wdata;
                pts_pkg::CFG_IDLE_SLOT: idle_slot_reg <= cfg_wdata[pts_pkg::ID_W-1:0];
                default:                tick_step_reg <= tick_step_reg;
            endcase
        end
    end

    // memory write ports
    assign pri_we      = create_ok;
    assign stack_we    = create_ok || (cmd.exec && (op == pts_pkg::REQ_SWITCH));
    assign stack_waddr = (op == pts_pkg::REQ_CREATE) ? total_slot : cur_reg;
    assign sleep_we    = (cmd.exec && (op == pts_pkg::REQ_SLEEP))
                         || (cmd.walk && pend_valid_reg && (op == pts_pkg::REQ_TICK)
                             && delayed_reg[pend_slot_reg] && !wakes);
    assign sleep_waddr = (op == pts_pkg::REQ_SLEEP) ? cur_reg : pend_slot_reg;
    assign sleep_wdata = (op == pts_pkg::REQ_SLEEP) ? ticks_reg
                         : sleep_rd_reg - pts_pkg::WORD_W'(tick_step_reg);

    always_ff @(posedge clk)
    begin
        if (pri_we)
        begin
            pri_mem[total_slot] <= pri_reg;
        end
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_in_reg;
        end
        if (sleep_we)
        begin
            sleep_mem[sleep_waddr] <= sleep_wdata;
        end
        pri_rd_reg   <= pri_mem[nslot];
        sleep_rd_reg <= sleep_mem[nslot];
        stack_rd_reg <= stack_mem[best_reg];
    end

    always_comb
    begin
        alive_next      = alive_reg;
        delayed_next    = delayed_reg;
        total_next      = total_reg;
        cur_next        = cur_reg;
        started_next    = started_reg;
        cnt_next        = cnt_reg;
        slot_next       = slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        best_next       = best_reg;
        best_pri_next   = best_pri_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        id_next         = id_reg;
        stack_out_next  = stack_out_reg;

        if (cmd.exec)
        begin
            cnt_next        = '0;
            slot_next       = cur_reg;
            pend_valid_next = 1'b0;
            best_next       = idle_wrap(idle_slot_reg);
            best_pri_next   = '0;
            if (!is_walk)
            begin
                done_next      = 1'b1;
                status_next    = 1'b0;
                id_next        = '0;
                stack_out_next = '0;
            end
            unique case (op)
                pts_pkg::REQ_CREATE:
                begin
                    if (full)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        alive_next[total_slot]   = 1'b1;
                        delayed_next[total_slot] = 1'b0;
                        total_next               = total_reg + TW'(1);
                        id_next                  = to_id(total_slot);
                    end
                end
                pts_pkg::REQ_DELETE:
                begin
                    if (32'(target_reg) < 32'(TASKS))
                    begin
                        alive_next[to_slot(target_reg)]   = 1'b0;
                        delayed_next[to_slot(target_reg)] = 1'b0;
                    end
                end
                pts_pkg::REQ_SLEEP:
                begin
                    delayed_next[cur_reg] = 1'b1;
                end
                default:
                begin
                    cnt_next = '0;
                end
            endcase
        end

        if (cmd.walk)
        begin
            pend_valid_next = issue;
            if (issue)
            begin
                cnt_next       = cnt_reg + TW'(1);
                slot_next      = nslot;
                pend_slot_next = nslot;
            end
            if (pend_valid_reg)
            begin
                if (op == pts_pkg::REQ_TICK)
                begin
                    if (delayed_reg[pend_slot_reg] && wakes)
                    begin
                        delayed_next[pend_slot_reg] = 1'b0;
                    end
                end
                else if (alive_reg[pend_slot_reg] && !delayed_reg[pend_slot_reg]
                         && (pri_rd_reg > best_pri_reg))
                begin
                    best_next     = pend_slot_reg;
                    best_pri_next = pri_rd_reg;
                end
            end
        end

        if (cmd.finish)
        begin
            done_next   = 1'b1;
            status_next = 1'b0;
            if (op == pts_pkg::REQ_TICK)
            begin
                id_next        = '0;
                stack_out_next = '0;
            end
            else
            begin
                id_next        = to_id(best_reg);
                stack_out_next = stack_rd_reg;
                cur_next       = best_reg;
                if (op == pts_pkg::REQ_START)
                begin
                    started_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg      <= '0;
            delayed_reg    <= '0;
            total_reg      <= '0;
            cur_reg        <= SW'(TASKS - 1);
            started_reg    <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            alive_reg      <= alive_next;
            delayed_reg    <= delayed_next;
            total_reg      <= total_next;
            cur_reg        <= cur_next;
            started_reg    <= started_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        pend_slot_reg <= pend_slot_next;
        best_reg      <= best_next;
        best_pri_reg  <= best_pri_next;
        status_reg    <= status_next;
        id_reg        <= id_next;
        stack_out_reg <= stack_out_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign task_id       = id_reg;
    assign stack_top_out = stack_out_reg;
    assign running       = started_reg;

    `PTS_ASSERT_SAME(a_total_bound, clk, rst_n, 1'b1, total_reg <= TW'(TASKS), "task count beyond table size")
    `PTS_ASSERT_SAME(a_walk_bound, clk, rst_n, 1'b1, cnt_reg <= total_reg, "slot walk ran past the created tasks")
    `PTS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "result strobe held for more than one cycle")

endmodule

`default_nettype wire

[src/priority_task_scheduler.sv]
// channel   | ports                                                    | handshake
// ----------+----------------------------------------------------------+--------------------------
// request   | req_type priority_req target_task sleep_ticks           | start high, busy low
//           | stack_top_in                                             |
// result    | status task_id stack_top_out running                     | done, one cycle, no stall
// config    | cfg_idx cfg_wdata                                        | cfg_we, taken every edge
//
// create, delete, sleep and unknown requests: the result is registered from the execute state
// tick, switch and start: a walk over the created slots, one slot per cycle through the
// task memories, in the execute, walk and finish states; the result is registered from finish
// busy is high from the cycle after acceptance until the result is loaded; a new request
// may be taken in the cycle that shows the result
// asynchronous active-low reset clears the task table state and loads register defaults
// the result receiver cannot stall; every result is shown exactly once

`default_nettype none

module priority_task_scheduler #(
    parameter int TASKS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pts_pkg::REQ_W-1:0]     req_type,
    input  wire logic [pts_pkg::PRI_W-1:0]     priority_req,
    input  wire logic [pts_pkg::ID_W-1:0]      target_task,
    input  wire logic [pts_pkg::WORD_W-1:0]    sleep_ticks,
    input  wire logic [pts_pkg::WORD_W-1:0]    stack_top_in,
    input  wire logic                          cfg_we,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [pts_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                               done,
    output logic                               status,
    output logic [pts_pkg::ID_W-1:0]           task_id,
    output logic [pts_pkg::WORD_W-1:0]         stack_top_out,
    output logic                               running
);

    pts_pkg::ctrl_cmd_t  cmd;
    pts_pkg::dp_status_t stat;

    pts_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    pts_datapath #(
        .TASKS (TASKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (req_type),
        .priority_req  (priority_req),
        .target_task   (target_task),
        .sleep_ticks   (sleep_ticks),
        .stack_top_in  (stack_top_in),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .status        (status),
        .task_id       (task_id),
        .stack_top_out (stack_top_out),
        .running       (running)
    );

endmodule

`default_nettype wire

[bench/priority_task_scheduler_tb.sv]
`default_nettype none

module priority_task_scheduler_tb;

    localparam int NSLOT       = 16;
    localparam int RUN_LIMIT   = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 92;
    localparam int SCRIPT_LEN  = 23;

    localparam logic [pts_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [pts_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd7;

    typedef struct packed {
        logic [pts_pkg::REQ_W-1:0]  kind;
        logic [pts_pkg::PRI_W-1:0]  pri;
        logic [pts_pkg::ID_W-1:0]   target;
        logic [pts_pkg::WORD_W-1:0] ticks;
        logic [pts_pkg::WORD_W-1:0] stack;
    } sched_req_t;

    typedef struct packed {
        logic                       status;
        logic [pts_pkg::ID_W-1:0]   id;
        logic [pts_pkg::WORD_W-1:0] stack;
        logic                       run;
    } sched_result_t;

    typedef struct packed {
        sched_req_t    req;
        logic          typed;
        sched_result_t res;
    } script_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [pts_pkg::REQ_W-1:0]     req_type;
    logic [pts_pkg::PRI_W-1:0]     priority_req;
    logic [pts_pkg::ID_W-1:0]      target_task;
    logic [pts_pkg::WORD_W-1:0]    sleep_ticks;
    logic [pts_pkg::WORD_W-1:0]    stack_top_in;
    logic                          cfg_we;
    logic [pts_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [pts_pkg::CFG_W-1:0]     cfg_wdata;
    logic                          done;
    logic                          status;
    logic [pts_pkg::ID_W-1:0]      task_id;
    logic [pts_pkg::WORD_W-1:0]    stack_top_out;
    logic                          running;

    priority_task_scheduler #(
        .TASKS(NSLOT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .priority_req (priority_req),
        .target_task  (target_task),
        .sleep_ticks  (sleep_ticks),
        .stack_top_in (stack_top_in),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .status       (status),
        .task_id      (task_id),
        .stack_top_out(stack_top_out),
        .running      (running)
    );

    // predicted task table
    logic [NSLOT-1:0]           t_alive;
    logic [NSLOT-1:0]           t_delayed;
    logic [NSLOT-1:0]           t_stack_set;
    logic [pts_pkg::PRI_W-1:0]  t_pri [NSLOT];
    logic [pts_pkg::WORD_W-1:0] t_sleep [NSLOT];
    logic [pts_pkg::WORD_W-1:0] t_stack [NSLOT];
    int unsigned                t_total;
    logic [pts_pkg::ID_W-1:0]   t_cur;
    logic                       t_started;
    logic [pts_pkg::STEP_W-1:0] t_step;
    logic [pts_pkg::ID_W-1:0]   t_idle;

    sched_result_t pending [$];
    sched_result_t head;

    int unsigned cycles;
    int          errors;
    int          requests;
    int          results_seen;
    int          refused;
    int          wakes;
    int          kind_count [8];

    script_row_t script [SCRIPT_LEN] = '{
        '{'{pts_pkg::REQ_SLEEP,  8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{1'b0, 4'h0, 32'h0000_0000, 1'b0}},
        '{'{pts_pkg::REQ_CREATE, 8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{1'b0, 4'h0, 32'h0000_0000, 1'b0}},
        '{'{pts_pkg::REQ_CREATE, 8'hff, 4'hf, 32'hffff_ffff, 32'hffff_ffff}, 1'b1,
          '{1'b0, 4'h1, 32'h0000_0000, 1'b0}},
        '{'{pts_pkg::REQ_SWITCH, 8'h00, 4'h0, 32'h0000_0000, 32'h8000_0001}, 1'b0, '0},
        '{'{pts_pkg::REQ_START,  8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{REQ_SPARE_A,         8'hff, 4'hf, 32'hffff_ffff, 32'hffff_ffff}, 1'b1,
          '{1'b0, 4'h0, 32'h0000_0000, 1'b1}},
        '{'{REQ_SPARE_B,         8'hff, 4'hf, 32'hffff_ffff, 32'hffff_ffff}, 1'b1,
          '{1'b0, 4'h0, 32'h0000_0000, 1'b1}},
        '{'{pts_pkg::REQ_SLEEP,  8'h00, 4'h0, 32'h0000_0003, 32'h0000_0000}, 1'b1,
          '{1'b0, 4'h0, 32'h0000_0000, 1'b1}},
        '{'{pts_pkg::REQ_SWITCH, 8'h00, 4'h0, 32'h0000_0000, 32'h1234_5678}, 1'b0, '0},
        '{'{pts_pkg::REQ_TICK,   8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{pts_pkg::REQ_TICK,   8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{pts_pkg::REQ_TICK,   8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{pts_pkg::REQ_SWITCH, 8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{pts_pkg::REQ_DELETE, 8'h00, 4'h1, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{1'b0, 4'h0, 32'h0000_0000, 1'b1}},
        '{'{pts_pkg::REQ_START,  8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{pts_pkg::REQ_DELETE, 8'h00, 4'hf, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{1'b0, 4'h0, 32'h0000_0000, 1'b1}},
        '{'{pts_pkg::REQ_SLEEP,  8'h00, 4'h0, 32'hffff_ffff, 32'h0000_0000}, 1'b0, '0},
        '{'{pts_pkg::REQ_CREATE, 8'h07, 4'h0, 32'h0000_0000, 32'haaaa_5555}, 1'b1,
          '{1'b0, 4'h2, 32'h0000_0000, 1'b1}},
        '{'{pts_pkg::REQ_CREATE, 8'h07, 4'h0, 32'h0000_0000, 32'h5555_aaaa}, 1'b1,
          '{1'b0, 4'h3, 32'h0000_0000, 1'b1}},
        '{'{pts_pkg::REQ_SWITCH, 8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{pts_pkg::REQ_SWITCH, 8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{pts_pkg::REQ_CREATE, 8'hff, 4'h0, 32'h0000_0000, 32'h0f0f_0f0f}, 1'b1,
          '{1'b0, 4'h4, 32'h0000_0000, 1'b1}},
        '{'{pts_pkg::REQ_TICK,   8'h00, 4'h0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0}
    };

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending.size());
            $display("simulation failed");
            $finish;
        end
    end

    // highest-priority pick, scanning from the slot after the current one; ties go to the first found
    function automatic logic [pts_pkg::ID_W-1:0] next_choice();
        int unsigned               slot;
        int unsigned               n;
        logic [pts_pkg::ID_W-1:0]  best;
        logic [pts_pkg::PRI_W-1:0] best_pri;
        slot = t_cur;
        best = t_idle;
        best_pri = '0;
        for (n = 0; n < t_total; n++)
        begin
            slot++;
            if (slot >= t_total)
                slot = 0;
            if (t_alive[slot] && !t_delayed[slot] && t_pri[slot] > best_pri)
            begin
                best = slot[pts_pkg::ID_W-1:0];
                best_pri = t_pri[slot];
            end
        end
        return best;
    endfunction

    function automatic sched_result_t schedule(sched_req_t r);
        sched_result_t            res;
        int                       i;
        logic [pts_pkg::ID_W-1:0] pick;
        res = '0;
        case (r.kind)
            pts_pkg::REQ_CREATE:
            begin
                if (t_total >= NSLOT)
                begin
                    res.status = 1'b1;
                    refused++;
                end
                else
                begin
                    t_pri[t_total] = r.pri;
                    t_alive[t_total] = 1'b1;
                    t_delayed[t_total] = 1'b0;
                    t_stack[t_total] = r.stack;
                    t_stack_set[t_total] = 1'b1;
                    res.id = t_total[pts_pkg::ID_W-1:0];
                    t_total++;
                end
            end
            pts_pkg::REQ_DELETE:
            begin
                t_alive[r.target] = 1'b0;
                t_delayed[r.target] = 1'b0;
            end
            pts_pkg::REQ_SLEEP:
            begin
                t_sleep[t_cur] = r.ticks;
                t_delayed[t_cur] = 1'b1;
            end
            pts_pkg::REQ_TICK:
            begin
                for (i = 0; i < int'(t_total); i++)
                begin
                    if (t_delayed[i])
                    begin
                        if (t_sleep[i] <= pts_pkg::WORD_W'(t_step))
                        begin
                            t_delayed[i] = 1'b0;
                            wakes++;
                        end
                        else
                            t_sleep[i] = t_sleep[i] - pts_pkg::WORD_W'(t_step);
                    end
                end
            end
            pts_pkg::REQ_SWITCH:
            begin
                t_stack[t_cur] = r.stack;
                t_stack_set[t_cur] = 1'b1;
                pick = next_choice();
                t_cur = pick;
                res.id = pick;
                res.stack = t_stack[pick];
            end
            pts_pkg::REQ_START:
            begin
                pick = next_choice();
                t_cur = pick;
                t_started = 1'b1;
                res.id = pick;
                res.stack = t_stack[pick];
            end
            default:
            begin
            end
        endcase
        res.run = t_started;
        return res;
    endfunction

    function automatic logic [pts_pkg::ID_W-1:0] any_stored_slot();
        logic [pts_pkg::ID_W-1:0] s;
        do
            s = pts_pkg::ID_W'($urandom_range(0, NSLOT - 1));
        while (!t_stack_set[s]);
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [pts_pkg::WORD_W-1:0] got,
                                   logic [pts_pkg::WORD_W-1:0] want);
        errors++;
        if (errors <= 30)
            $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    task automatic issue(sched_req_t r, logic typed, sched_result_t typed_res);
        sched_result_t res;
        start <= 1'b1;
        req_type <= r.kind;
        priority_req <= r.pri;
        target_task <= r.target;
        sleep_ticks <= r.ticks;
        stack_top_in <= r.stack;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        res = schedule(r);
        pending.push_back(typed ? typed_res : res);
        kind_count[r.kind]++;
        requests++;
    endtask

    task automatic maybe_pause(bit allowed);
        int n;
        if (allowed && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (NSLOT + 8) @(posedge clk);
    endtask

    task automatic load_regs(logic [pts_pkg::STEP_W-1:0] step, logic [pts_pkg::ID_W-1:0] idle);
        cfg_we <= 1'b1;
        cfg_idx <= pts_pkg::CFG_TICK_STEP;
        cfg_wdata <= pts_pkg::CFG_W'(step);
        @(posedge clk);
        t_step = step;
        cfg_idx <= pts_pkg::CFG_IDLE_SLOT;
        cfg_wdata <= pts_pkg::CFG_W'(idle);
        @(posedge clk);
        t_idle = idle;
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            if (pending.size() == 0)
                report_mismatch("result with no request pending",
                                pts_pkg::WORD_W'(task_id), '0);
            else
            begin
                head = pending.pop_front();
                if (status !== head.status)
                    report_mismatch("status", pts_pkg::WORD_W'(status),
                                    pts_pkg::WORD_W'(head.status));
                if (task_id !== head.id)
                    report_mismatch("task_id", pts_pkg::WORD_W'(task_id),
                                    pts_pkg::WORD_W'(head.id));
                if (stack_top_out !== head.stack)
                    report_mismatch("stack_top_out", stack_top_out, head.stack);
                if (running !== head.run)
                    report_mismatch("running", pts_pkg::WORD_W'(running),
                                    pts_pkg::WORD_W'(head.run));
            end
        end
    end

    initial
    begin
        int            ph;
        int            k;
        int            w;
        int            pick;
        sched_req_t    r;
        sched_result_t none;

        none = '0;
        clk = 1'b0;
        rst_n <= 1'b0;
        start <= 1'b0;
        req_type <= '0;
        priority_req <= '0;
        target_task <= '0;
        sleep_ticks <= '0;
        stack_top_in <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_wdata <= '0;

        t_alive = '0;
        t_delayed = '0;
        t_stack_set = '0;
        t_total = 0;
        t_cur = pts_pkg::ID_W'(NSLOT - 1);
        t_started = 1'b0;
        t_step = pts_pkg::TICK_STEP_RESET;
        t_idle = pts_pkg::IDLE_SLOT_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < SCRIPT_LEN; k++)
        begin
            issue(script[k].req, script[k].typed, script[k].res);
            maybe_pause(1'b1);
        end

        // randomised phases, each under its own register setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0: load_regs(16'hffff, 4'd15);
                1: load_regs(16'd2, any_stored_slot());
                2: load_regs(pts_pkg::STEP_W'($urandom_range(1, 65535)), 4'd0);
                3: load_regs(16'd3, any_stored_slot());
                4: load_regs(pts_pkg::STEP_W'($urandom_range(1, 8)), 4'd15);
                5: load_regs(16'd1, any_stored_slot());
                6: load_regs(16'hffff, 4'd0);
                default: load_regs(pts_pkg::STEP_W'($urandom_range(1, 16)), any_stored_slot());
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                r.pri = pts_pkg::PRI_W'($urandom);
                r.target = pts_pkg::ID_W'($urandom);
                r.ticks = $urandom;
                r.stack = $urandom;
                w = $urandom_range(0, 99);
                if (w < 5)
                begin
                    r.kind = pts_pkg::REQ_CREATE;
                    if ($urandom_range(0, 1) == 0)
                        r.pri = pts_pkg::PRI_W'($urandom_range(0, 3));
                end
                else if (w < 7)
                    r.kind = pts_pkg::REQ_DELETE;
                else if (w < 22)
                begin
                    r.kind = pts_pkg::REQ_SLEEP;
                    case ($urandom_range(0, 4))
                        0, 1, 2: r.ticks = $urandom_range(0, 40);
                        3: r.ticks = pts_pkg::WORD_W'(t_step) * $urandom_range(0, 3)
                                     + $urandom_range(0, 1);
                        default: r.ticks = $urandom;
                    endcase
                end
                else if (w < 55)
                    r.kind = pts_pkg::REQ_TICK;
                else if (w < 87)
                    r.kind = pts_pkg::REQ_SWITCH;
                else if (w < 96)
                    r.kind = pts_pkg::REQ_START;
                else
                    r.kind = ($urandom_range(0, 1) == 0) ? REQ_SPARE_A : REQ_SPARE_B;

                // never let a pick land on a slot whose stack top was never stored
                if (r.kind == pts_pkg::REQ_SWITCH || r.kind == pts_pkg::REQ_START)
                begin
                    pick = next_choice();
                    if (!t_stack_set[pick] && !(r.kind == pts_pkg::REQ_SWITCH && pick == t_cur))
                        r.kind = pts_pkg::REQ_TICK;
                end

                issue(r, 1'b0, none);
                maybe_pause(ph < PHASES - 1);
            end
        end

        drain();

        $display("%0d requests: %0d create, %0d delete, %0d sleep, %0d tick, %0d switch,",
                 requests, kind_count[pts_pkg::REQ_CREATE], kind_count[pts_pkg::REQ_DELETE],
                 kind_count[pts_pkg::REQ_SLEEP], kind_count[pts_pkg::REQ_TICK],
                 kind_count[pts_pkg::REQ_SWITCH]);
        $display("%0d start, %0d unknown; %0d results, %0d creates refused, %0d woken, %0d settings",
                 kind_count[pts_pkg::REQ_START],
                 kind_count[REQ_SPARE_A] + kind_count[REQ_SPARE_B],
                 results_seen, refused, wakes, PHASES);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
